// ----- rtl/windowed_bus_address_decoder_assert.svh -----
// assertion macros shared by the decoder checkers
`ifndef WINDOWED_BUS_ADDRESS_DECODER_ASSERT_SVH
`define WINDOWED_BUS_ADDRESS_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define WBAD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbad same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define WBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbad next-cycle check failed");

`endif

// ----- rtl/wbad_pkg.sv -----
package wbad_pkg;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int REG_W     = 33;
    localparam int CFG_IDX_W = 4;
    localparam int IDX_W     = 3;
    localparam int STAT_W    = 2;
    localparam int M_DATA_W  = 16;
    localparam int S_DATA_W  = 24;

    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_MISS  = 2'd0,
        ST_HIT   = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

endpackage

// ----- rtl/windowed_bus_address_decoder.sv -----
// pipeline: an accepted transaction passes the stage 1 register and the stage 2 output register
// throughput: one transaction per cycle while m_tready is high, set by the single port of the byte store
// reset: window registers clear at once; the byte store is then cleared in a
// pass over all NUM_WINDOWS * WINDOW_BYTES bytes (32768 at the defaults), one byte
// per cycle, during which s_tready stays low; configuration writes are taken
module windowed_bus_address_decoder
    import wbad_pkg::*;
#(
    parameter int NUM_WINDOWS  = 8,
    parameter int WINDOW_BYTES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    // request side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // address[15:0], write_data[23:16]
    input  logic                 s_tuser,   // req_type[0]
    // result side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // read_data[7:0], window_index[10:8],
                                            // notify[11], zero[15:12]
    output logic [STAT_W-1:0]    m_tuser    // status[1:0]
);

    localparam int DEPTH = NUM_WINDOWS * WINDOW_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [ADDR_W:0]  WB_LIM    = (ADDR_W+1)'(WINDOW_BYTES);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(DEPTH - 1);

    // window registers: [15:0] start, [31:16] end exclusive, [32] notify enable
    logic [REG_W-1:0] win_reg [NUM_WINDOWS];

    // clearing pass
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_done_reg;

    // stage 1: decoded transaction
    logic              v1_reg;
    logic              wr1_reg;
    logic [DATA_W-1:0] data1_reg;
    status_t           status1_reg;
    logic [IDX_W-1:0]  idx1_reg;
    logic              ntf1_reg;
    logic [ADDR_W-1:0] off1_reg;

    // stage 2: output register, read byte comes from the store read register
    logic              v2_reg;
    logic              rdsel2_reg;
    status_t           status2_reg;
    logic [IDX_W-1:0]  idx2_reg;
    logic              ntf2_reg;

    // byte store
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_rdata_reg;

    // decode results
    logic              dec_hit;
    logic [IDX_W-1:0]  dec_idx;
    logic              dec_ntf;
    logic [ADDR_W-1:0] dec_off;
    status_t           dec_status;

    logic              en1;
    logic              en2;
    logic              s_acc;
    logic              mem_en;
    logic [AW-1:0]     mem_addr;

    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_data;

    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_data = s_tdata[ADDR_W +: DATA_W];

    // stage enables: a stage moves when the one after it can take its content
    assign en2      = !v2_reg || m_tready;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1 && clr_done_reg;
    assign s_acc    = s_tvalid && s_tready;

    // configuration writes, indexes past the window count are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WINDOWS; w++)
            begin
                win_reg[w] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            for (int w = 0; w < NUM_WINDOWS; w++)
            begin
                if (cfg_index == CFG_IDX_W'(w))
                begin
                    win_reg[w] <= cfg_data;
                end
            end
        end
    end

    // NUM_WINDOWS parallel range compares; the highest matching window wins
    always_comb
    begin
        logic [ADDR_W-1:0] w_start;
        logic [ADDR_W-1:0] w_end;
        dec_hit = 1'b0;
        dec_idx = '0;
        dec_ntf = 1'b0;
        dec_off = '0;
        for (int w = 0; w < NUM_WINDOWS; w++)
        begin
            w_start = win_reg[w][ADDR_W-1:0];
            w_end   = win_reg[w][2*ADDR_W-1:ADDR_W];
            if (in_addr >= w_start && in_addr < w_end)
            begin
                dec_hit = 1'b1;
                dec_idx = IDX_W'(w);
                dec_ntf = win_reg[w][REG_W-1];
                dec_off = in_addr - w_start;
            end
        end
        if (!dec_hit)
        begin
            dec_status = ST_MISS;
        end
        else if ({1'b0, dec_off} >= WB_LIM)
        begin
            dec_status = ST_RANGE;
        end
        else
        begin
            dec_status = ST_HIT;
        end
    end

    // stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= s_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            wr1_reg     <= (s_tuser == REQ_WRITE);
            data1_reg   <= in_data;
            status1_reg <= dec_status;
            idx1_reg    <= dec_idx;
            ntf1_reg    <= dec_ntf;
            off1_reg    <= dec_off;
        end
    end

    // store access happens as stage 1 moves into stage 2
    assign mem_en   = v1_reg && en2 && (status1_reg == ST_HIT);
    assign mem_addr = AW'(int'(idx1_reg) * WINDOW_BYTES + int'(off1_reg));

    // clearing pass after reset, no transaction is taken until it ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == CLR_LAST)
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // single-port byte store with registered read
    always_ff @(posedge clk)
    begin
        if (!clr_done_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (mem_en)
        begin
            if (wr1_reg)
            begin
                mem[mem_addr] <= data1_reg;
            end
            else
            begin
                mem_rdata_reg <= mem[mem_addr];
            end
        end
    end

    // stage 2 / output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            rdsel2_reg  <= (status1_reg == ST_HIT) && !wr1_reg;
            status2_reg <= status1_reg;
            idx2_reg    <= idx1_reg;
            ntf2_reg    <= ntf1_reg;
        end
    end

    // read data is zero on a miss, on an out-of-store offset and on writes
    assign m_tvalid = v2_reg;
    assign m_tdata  = {4'b0000, ntf2_reg, idx2_reg,
                       (rdsel2_reg ? mem_rdata_reg : {DATA_W{1'b0}})};
    assign m_tuser  = status2_reg;

endmodule

// ----- rtl/wbad_checker.sv -----
`include "windowed_bus_address_decoder_assert.svh"

module wbad_checker
    import wbad_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]   m_tuser
);

    logic miss;
    logic out_range;

    assign miss      = (m_tuser == ST_MISS);
    assign out_range = (m_tuser == ST_RANGE);

    // a miss reports no window, no notify and no data
    `WBAD_ASSERT_SAME(a_miss_clean, clk, rst_n, m_tvalid && miss, m_tdata == '0)

    // status code 3 is never produced
    `WBAD_ASSERT_SAME(a_status_legal, clk, rst_n, m_tvalid, miss || out_range || (m_tuser == ST_HIT))

    // an offset beyond the store never returns data
    `WBAD_ASSERT_SAME(a_range_no_data, clk, rst_n, m_tvalid && out_range, m_tdata[7:0] == 8'h00)

    // a stalled result holds
    `WBAD_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind windowed_bus_address_decoder wbad_checker u_wbad_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import wbad_pkg::*;

    // block configuration, kept at the defaults of the decoder
    localparam int NUM_WIN   = 8;
    localparam int WIN_BYTES = 4096;

    // register indexes: one per window, the indexes above them are spare
    localparam int REG_WINDOW_BASE = 0;
    localparam int REG_SPARE_FIRST = 8;
    localparam int REG_SPARE_LAST  = 15;

    localparam logic REQ_READ = ~REQ_WRITE;

    // run shape
    localparam int NUM_BLOCKS      = 6;
    localparam int ITEMS_PER_BLOCK = 75;
    localparam int SETUP_ROW       = 3;
    localparam int TAIL_CYCLES     = 12;
    localparam int LIMIT_CYCLES    = 200000;

    typedef struct packed {
        logic        req;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } access_t;

    typedef struct packed {
        logic [7:0] rd;
        status_t    st;
        logic [2:0] idx;
        logic       ntf;
    } outcome_t;

    typedef struct packed {
        access_t  acc;
        logic     typed;   // reply written out below, else taken from the decode model
        outcome_t res;
    } probe_t;

    localparam int NUM_PROBES = 23;

    // directed probes; the first SETUP_ROW run with every window empty,
    // the rest under DIRECTED_WINDOWS
    localparam probe_t PROBES [NUM_PROBES] = '{
        // all windows empty after reset
        '{'{REQ_READ,  16'h0000, 8'h00}, 1'b1, '{8'h00, ST_MISS,  3'd0, 1'b0}},
        '{'{REQ_WRITE, 16'hFFFF, 8'hFF}, 1'b1, '{8'h00, ST_MISS,  3'd0, 1'b0}},
        '{'{REQ_READ,  16'h8000, 8'hFF}, 1'b1, '{8'h00, ST_MISS,  3'd0, 1'b0}},
        // window 0 spans the bus below 16'hFFFF, first and last byte of its store
        '{'{REQ_WRITE, 16'h0000, 8'hFF}, 1'b1, '{8'h00, ST_HIT,   3'd0, 1'b0}},
        '{'{REQ_READ,  16'h0000, 8'h00}, 1'b1, '{8'hFF, ST_HIT,   3'd0, 1'b0}},
        '{'{REQ_READ,  16'h0FFF, 8'h00}, 1'b1, '{8'h00, ST_HIT,   3'd0, 1'b0}},
        // window 1 with notify, its first and last address
        '{'{REQ_WRITE, 16'h1000, 8'hA5}, 1'b1, '{8'h00, ST_HIT,   3'd1, 1'b1}},
        '{'{REQ_READ,  16'h1000, 8'h00}, 1'b1, '{8'hA5, ST_HIT,   3'd1, 1'b1}},
        '{'{REQ_READ,  16'h17FF, 8'h00}, 1'b1, '{8'h00, ST_HIT,   3'd1, 1'b1}},
        // end is exclusive, falls back to window 0 beyond its store
        '{'{REQ_READ,  16'h1800, 8'h00}, 1'b1, '{8'h00, ST_RANGE, 3'd0, 1'b0}},
        // windows 2 and 3 are empty, write is dropped
        '{'{REQ_WRITE, 16'h3000, 8'h3C}, 1'b1, '{8'h00, ST_RANGE, 3'd0, 1'b0}},
        // windows 4 and 5 overlap, the higher one wins
        '{'{REQ_READ,  16'h2000, 8'h00}, 1'b1, '{8'h00, ST_HIT,   3'd4, 1'b1}},
        '{'{REQ_WRITE, 16'h2080, 8'h5A}, 1'b1, '{8'h00, ST_HIT,   3'd5, 1'b0}},
        '{'{REQ_READ,  16'h2080, 8'h00}, 1'b0, '{8'h00, ST_MISS,  3'd0, 1'b0}},
        '{'{REQ_READ,  16'h207F, 8'h00}, 1'b1, '{8'h00, ST_HIT,   3'd4, 1'b1}},
        // window 6 is larger than its store
        '{'{REQ_WRITE, 16'h9000, 8'h11}, 1'b1, '{8'h00, ST_RANGE, 3'd6, 1'b1}},
        '{'{REQ_READ,  16'h9000, 8'h00}, 1'b1, '{8'h00, ST_RANGE, 3'd6, 1'b1}},
        '{'{REQ_WRITE, 16'h8FFF, 8'h22}, 1'b1, '{8'h00, ST_HIT,   3'd6, 1'b1}},
        '{'{REQ_READ,  16'h8FFF, 8'h00}, 1'b0, '{8'h00, ST_MISS,  3'd0, 1'b0}},
        // window 7 on top of window 0 at the top of the bus
        '{'{REQ_WRITE, 16'hFFFE, 8'h80}, 1'b1, '{8'h00, ST_HIT,   3'd7, 1'b1}},
        '{'{REQ_READ,  16'hFFFE, 8'h00}, 1'b1, '{8'h80, ST_HIT,   3'd7, 1'b1}},
        '{'{REQ_READ,  16'hFFFF, 8'h00}, 1'b1, '{8'h00, ST_MISS,  3'd0, 1'b0}},
        '{'{REQ_READ,  16'hF000, 8'h00}, 1'b1, '{8'h00, ST_HIT,   3'd7, 1'b1}}
    };

    // {notify, end, start} per window
    localparam bit [REG_W-1:0] DIRECTED_WINDOWS [NUM_WIN] = '{
        {1'b0, 16'hFFFF, 16'h0000},
        {1'b1, 16'h1800, 16'h1000},
        {1'b1, 16'h3000, 16'h3000},
        {1'b1, 16'h2000, 16'h4000},
        {1'b1, 16'h2100, 16'h2000},
        {1'b0, 16'h2200, 16'h2080},
        {1'b1, 16'hA000, 16'h8000},
        {1'b1, 16'hFFFF, 16'hF000}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // decode model state: window registers and the byte stores of all windows
    bit [REG_W-1:0] win_reg    [NUM_WIN];
    bit [REG_W-1:0] staged_reg [NUM_WIN];
    bit [7:0]       byte_store [NUM_WIN*WIN_BYTES];

    outcome_t replies_due[$];
    bit       failed;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       cycle_count;

    windowed_bus_address_decoder #(
        .NUM_WINDOWS  (NUM_WIN),
        .WINDOW_BYTES (WIN_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit, sized well above the slowest legal run including the store clear
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [REG_W-1:0] pack_window(input logic [15:0] lo,
                                                     input logic [15:0] hi,
                                                     input logic ntf);
        return {ntf, hi, lo};
    endfunction

    // decode one access: highest matching window wins, store updated on a write hit
    function automatic outcome_t decode_access(input access_t acc);
        outcome_t    res;
        int          w;
        int unsigned lo;
        int unsigned hi;
        int unsigned off;
        res = '{rd: 8'h00, st: ST_MISS, idx: 3'd0, ntf: 1'b0};
        for (w = NUM_WIN - 1; w >= 0; w--)
        begin
            lo = 32'(win_reg[w][15:0]);
            hi = 32'(win_reg[w][31:16]);
            if (acc.addr >= lo && acc.addr < hi)
            begin
                off     = acc.addr - lo;
                res.idx = w[2:0];
                res.ntf = win_reg[w][32];
                if (off >= WIN_BYTES)
                    res.st = ST_RANGE;
                else
                begin
                    res.st = ST_HIT;
                    if (acc.req == REQ_WRITE)
                        byte_store[w*WIN_BYTES + off] = acc.wdata;
                    else
                        res.rd = byte_store[w*WIN_BYTES + off];
                end
                break;
            end
        end
        return res;
    endfunction

    // mostly real windows of a few kilobytes, some empty, some arbitrary bit patterns
    function automatic logic [REG_W-1:0] random_window();
        logic [REG_W-1:0] raw;
        int unsigned      sel;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      span;
        sel = $urandom_range(99);
        lo  = $urandom_range(65535);
        if (sel < 65)
        begin
            span = ($urandom_range(3) == 0) ? $urandom_range(1, 12000)
                                            : $urandom_range(1, 3000);
            hi   = (lo + span > 65535) ? 65535 : lo + span;
        end
        else if (sel < 80)
            hi = $urandom_range(lo);   // end at or below start
        else
        begin
            raw[31:0] = $urandom();
            raw[32]   = 1'($urandom_range(1));
            return raw;
        end
        return pack_window(lo[15:0], hi[15:0], $urandom_range(1) != 0);
    endfunction

    // aim most accesses into a window, often at its first bytes so reads find writes
    function automatic access_t random_access();
        access_t     acc;
        int unsigned w;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        int unsigned off;
        w  = $urandom_range(NUM_WIN - 1);
        lo = 32'(win_reg[w][15:0]);
        hi = 32'(win_reg[w][31:16]);
        if ($urandom_range(99) < 75 && hi > lo)
        begin
            span     = hi - lo;
            off      = ($urandom_range(99) < 60) ? $urandom_range(15) % span
                                                 : $urandom_range(span - 1);
            acc.addr = 16'(lo + off);
        end
        else
            acc.addr = 16'($urandom_range(65535));
        acc.req   = ($urandom_range(1) != 0) ? REQ_WRITE : REQ_READ;
        acc.wdata = 8'($urandom_range(255));
        return acc;
    endfunction

    // window layout for each random block; two of them are extreme layouts
    task automatic stage_block_windows(input int blk);
        int w;
        for (w = 0; w < NUM_WIN; w++)
            staged_reg[w] = random_window();
        case (blk)
            1:
            begin
                staged_reg[0] = pack_window(16'h0000, 16'hFFFF, 1'b1);
                staged_reg[3] = '0;
                staged_reg[7] = '1;
            end
            3:
                // every window spans the bus below 16'hFFFF, window 7 takes every hit
                for (w = 0; w < NUM_WIN; w++)
                    staged_reg[w] = pack_window(16'h0000, 16'hFFFF,
                                                $urandom_range(1) != 0);
            default: ;
        endcase
    endtask

    // wait until every issued transaction has come back, sender parked
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // one register write per edge, then two writes to spare indexes that must do nothing
    task automatic program_windows();
        int       w;
        int       k;
        bit [3:0] spare;
        for (w = 0; w < NUM_WIN; w++)
        begin
            cfg_wr_en  <= 1'b1;
            cfg_index  <= CFG_IDX_W'(REG_WINDOW_BASE + w);
            cfg_data   <= staged_reg[w];
            win_reg[w]  = staged_reg[w];
            @(posedge clk);
        end
        for (k = 0; k < 2; k++)
        begin
            spare      = 4'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
            cfg_wr_en <= 1'b1;
            cfg_index <= spare;
            cfg_data  <= {1'($urandom_range(1)), $urandom()};
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // drive one bus transaction, hold it until taken, then queue its reply
    task automatic issue_access(input access_t acc, input logic typed,
                                input outcome_t typed_res);
        outcome_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {acc.wdata, acc.addr};
        s_tuser  <= acc.req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // taken at this edge; the model still runs to keep its stores in step
        res = decode_access(acc);
        if (typed)
            replies_due.push_back(typed_res);
        else
            replies_due.push_back(res);
    endtask

    task automatic check_reply();
        outcome_t exp;
        if (replies_due.size() == 0)
        begin
            $error("reply transaction with nothing outstanding: tdata %h tuser %0d",
                   m_tdata, m_tuser);
            failed = 1'b1;
        end
        else
        begin
            exp = replies_due.pop_front();
            if (m_tdata[7:0] !== exp.rd)
            begin
                $error("read_data mismatch: expected %0h, got %0h", exp.rd, m_tdata[7:0]);
                failed = 1'b1;
            end
            if (m_tuser !== exp.st)
            begin
                $error("status mismatch: expected %0d, got %0d", exp.st, m_tuser);
                failed = 1'b1;
            end
            if (m_tdata[10:8] !== exp.idx)
            begin
                $error("window_index mismatch: expected %0d, got %0d",
                       exp.idx, m_tdata[10:8]);
                failed = 1'b1;
            end
            if (m_tdata[11] !== exp.ntf)
            begin
                $error("notify mismatch: expected %0d, got %0d", exp.ntf, m_tdata[11]);
                failed = 1'b1;
            end
            if (m_tdata[15:12] !== 4'd0)
            begin
                $error("tdata pad mismatch: expected 0, got %0h", m_tdata[15:12]);
                failed = 1'b1;
            end
        end
    endtask

    // reply side: check on the handshake edge, then pick the next ready level
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_reply();
            m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int i;
        int blk;
        int n;
        failed        = 1'b0;
        cycle_count   = 0;
        send_idle_pct = 14;
        recv_idle_pct = 64;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed probes; the decoder holds off requests while it clears its stores
        for (i = 0; i < NUM_PROBES; i++)
        begin
            if (i == SETUP_ROW)
            begin
                drain_replies();
                staged_reg = DIRECTED_WINDOWS;
                program_windows();
            end
            issue_access(PROBES[i].acc, PROBES[i].typed, PROBES[i].res);
        end

        // random blocks: two per idle mode, a fresh window layout for each
        for (blk = 0; blk < NUM_BLOCKS; blk++)
        begin
            case (blk / 2)
                0:       begin send_idle_pct = 14; recv_idle_pct = 64; end
                1:       begin send_idle_pct = 64; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            drain_replies();
            stage_block_windows(blk);
            program_windows();
            for (n = 0; n < ITEMS_PER_BLOCK; n++)
                issue_access(random_access(), 1'b0, '0);
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (!failed && replies_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
